// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nci check failed");

// Next-cycle implication, quiet while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nci check failed");

`endif

// ----- rtl/nci_pkg.sv -----
`timescale 1ns / 1ps

package nci_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int STEP_W        = 32;
  localparam int WEIGHT_W      = 12;
  localparam int CFG_W         = 32;
  localparam int COUNT_FIELD_W = 13;
  localparam int MIN_COUNT     = 2;
  localparam int SHORT_MAX     = 6;

  // config register indexes
  localparam logic [0:0] REG_COUNT = 1'b0;
  localparam logic [0:0] REG_STEP  = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 32'd65536;

  // extended rule weights, scaled by 1440
  localparam logic [WEIGHT_W-1:0] W_EDGE0 = 12'd540;
  localparam logic [WEIGHT_W-1:0] W_EDGE1 = 12'd1680;
  localparam logic [WEIGHT_W-1:0] W_EDGE2 = 12'd1380;
  localparam logic [WEIGHT_W-1:0] W_INNER = 12'd1440;

  // 1440 * 65536 = 45 * 2^21; rounding adds half of that first
  localparam int          ROUND_SHIFT = 21;
  localparam logic [25:0] HALF_DIV    = 26'd47185920;
  localparam logic [6:0]  DIVISOR     = 7'd45;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic                take;
    logic [WEIGHT_W-1:0] weight;
    logic                clear_sum;
    logic                load_mag;
    logic                mul_lo;
    logic                mul_hi;
    logic                add_hi;
    logic                div_step;
    logic                emit;
  } nci_cmd_t;

  // closed rules for runs of 2 to 6 samples, weights scaled by 1440
  function automatic logic [WEIGHT_W-1:0] short_weight(input logic [2:0] n,
                                                       input logic [2:0] k);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    case (n)
      3'd2: begin
        case (k)
          3'd0, 3'd1: w = 12'd720;
          default:    w = '0;
        endcase
      end
      3'd3: begin
        case (k)
          3'd0, 3'd2: w = 12'd480;
          3'd1:       w = 12'd1920;
          default:    w = '0;
        endcase
      end
      3'd4: begin
        case (k)
          3'd0, 3'd3: w = 12'd540;
          3'd1, 3'd2: w = 12'd1620;
          default:    w = '0;
        endcase
      end
      3'd5: begin
        case (k)
          3'd0, 3'd4: w = 12'd448;
          3'd1, 3'd3: w = 12'd2048;
          3'd2:       w = 12'd768;
          default:    w = '0;
        endcase
      end
      3'd6: begin
        case (k)
          3'd0, 3'd5: w = 12'd475;
          3'd1, 3'd4: w = 12'd1875;
          3'd2, 3'd3: w = 12'd1250;
          default:    w = '0;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/nci_ctrl.sv -----
`timescale 1ns / 1ps

module nci_ctrl
  import nci_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096,
  parameter int DIV_STEPS   = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             wr_en,
  input  logic [0:0]       wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output logic             busy,
  output nci_cmd_t         cmd
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int DSTEP_W = $clog2(DIV_STEPS);

  localparam logic [3:0] ST_RUN     = 4'd0;
  localparam logic [3:0] ST_DRAIN_A = 4'd1;
  localparam logic [3:0] ST_DRAIN_B = 4'd2;
  localparam logic [3:0] ST_MAG     = 4'd3;
  localparam logic [3:0] ST_MUL_LO  = 4'd4;
  localparam logic [3:0] ST_MUL_HI  = 4'd5;
  localparam logic [3:0] ST_ADD     = 4'd6;
  localparam logic [3:0] ST_DIV     = 4'd7;
  localparam logic [3:0] ST_EMIT    = 4'd8;

  logic [3:0]          state, state_next;
  logic [CNT_W-1:0]    count_m1, count_m2, count_m3;
  logic                is_short;
  logic [2:0]          short_n;
  logic [IDX_W-1:0]    index;
  logic [DSTEP_W-1:0]  div_cnt;
  logic [CFG_W-1:0]    cnt_wide, cnt_clamp;
  logic [CNT_W-1:0]    n_new, k_ext;
  logic [WEIGHT_W-1:0] weight;
  logic                last, accept, cnt_wr;

  assign accept = start && (state == ST_RUN);
  assign busy   = (state != ST_RUN);
  assign cnt_wr = wr_en && (wr_index == REG_COUNT);

  // run length write: 13-bit field, clamped to the legal range
  always_comb begin
    cnt_wide = CFG_W'(wr_data[COUNT_FIELD_W-1:0]);
    if (cnt_wide < CFG_W'(MIN_COUNT)) begin
      cnt_clamp = CFG_W'(MIN_COUNT);
    end else if (cnt_wide > CFG_W'(MAX_SAMPLES)) begin
      cnt_clamp = CFG_W'(MAX_SAMPLES);
    end else begin
      cnt_clamp = cnt_wide;
    end
    n_new = cnt_clamp[CNT_W-1:0];
  end

  // weight of the sample at the current position
  always_comb begin
    k_ext = CNT_W'(index);
    last  = (k_ext == count_m1);
    if (is_short) begin
      weight = short_weight(short_n, index[2:0]);
    end else if (k_ext == '0 || k_ext == count_m1) begin
      weight = W_EDGE0;
    end else if (k_ext == CNT_W'(1) || k_ext == count_m2) begin
      weight = W_EDGE1;
    end else if (k_ext == CNT_W'(2) || k_ext == count_m3) begin
      weight = W_EDGE2;
    end else begin
      weight = W_INNER;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (accept && last) state_next = ST_DRAIN_A;
      end
      ST_DRAIN_A: state_next = ST_DRAIN_B;
      ST_DRAIN_B: state_next = ST_MAG;
      ST_MAG:     state_next = ST_MUL_LO;
      ST_MUL_LO:  state_next = ST_MUL_HI;
      ST_MUL_HI:  state_next = ST_ADD;
      ST_ADD:     state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == DSTEP_W'(DIV_STEPS - 1)) state_next = ST_EMIT;
      end
      ST_EMIT:    state_next = ST_RUN;
      default:    state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      index    <= '0;
      div_cnt  <= '0;
      count_m1 <= CNT_W'(1);
      count_m2 <= '0;
      count_m3 <= '1;
      is_short <= 1'b1;
      short_n  <= 3'd2;
    end else begin
      state <= state_next;
      // a new run length restarts the run
      if (cnt_wr) begin
        count_m1 <= n_new - CNT_W'(1);
        count_m2 <= n_new - CNT_W'(2);
        count_m3 <= n_new - CNT_W'(3);
        is_short <= (n_new <= CNT_W'(SHORT_MAX));
        short_n  <= n_new[2:0];
        index    <= '0;
      end else if (accept) begin
        index <= last ? '0 : index + IDX_W'(1);
      end
      if (state == ST_DIV) begin
        div_cnt <= div_cnt + DSTEP_W'(1);
      end else begin
        div_cnt <= '0;
      end
    end
  end

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.take      = accept;
    cmd.weight    = weight;
    cmd.clear_sum = cnt_wr || (state == ST_MAG);
    cmd.load_mag  = (state == ST_MAG);
    cmd.mul_lo    = (state == ST_MUL_LO);
    cmd.mul_hi    = (state == ST_MUL_HI);
    cmd.add_hi    = (state == ST_ADD);
    cmd.div_step  = (state == ST_DIV);
    cmd.emit      = (state == ST_EMIT);
  end

endmodule

// ----- rtl/nci_dp.sv -----
`timescale 1ns / 1ps

module nci_dp
  import nci_pkg::*;
#(
  parameter int SUM_W = 56,
  parameter int MAG_W = 55,
  parameter int DIV_W = 68
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nci_cmd_t                   cmd,
  input  logic                       wr_en,
  input  logic [0:0]                 wr_index,
  input  logic [CFG_W-1:0]           wr_data,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [63:0]         integral,
  output logic                       saturated,
  output logic                       done
);

  localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;
  localparam int LO_W   = 32;
  localparam int PART_W = LO_W + STEP_W;
  localparam int ACC_W  = MAG_W + STEP_W + 1;
  localparam int CMP_W  = (DIV_W > 64) ? DIV_W : 65;

  logic [STEP_W-1:0]          step;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [WEIGHT_W-1:0]        s1_weight;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]    sum, sum_abs;
  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic [PART_W-1:0]          part;
  logic [ACC_W-1:0]           acc, acc_full;
  logic [DIV_W-1:0]           quo, quo_next;
  logic [5:0]                 rem, rem_next;
  logic [CMP_W-1:0]           quo_ext;
  logic [63:0]                limit, res;
  logic                       over;

  // step width register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RESET;
    end else if (wr_en && wr_index == REG_STEP) begin
      step <= wr_data[STEP_W-1:0];
    end
  end

  // sample beat -> weight product -> running sum; idle slots carry weight 0
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_weight <= '0;
      prod      <= '0;
      sum       <= '0;
    end else begin
      if (cmd.take) begin
        s1_weight <= cmd.weight;
      end else begin
        s1_weight <= '0;
      end
      prod <= PROD_W'(s1_sample * $signed({1'b0, s1_weight}));
      if (cmd.clear_sum) begin
        sum <= '0;
      end else begin
        sum <= sum + SUM_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) s1_sample <= sample;
  end

  assign sum_abs  = sum[SUM_W-1] ? -sum : sum;
  assign acc_full = acc + (ACC_W'(part) << LO_W);

  // radix-16 restoring divide by 45
  always_comb begin
    logic [6:0]       t;
    logic [5:0]       r;
    logic [DIV_W-1:0] q;
    r = rem;
    q = quo;
    for (int j = 0; j < 4; j++) begin
      t = {r, q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (t >= DIVISOR) begin
        r    = 6'(t - DIVISOR);
        q[0] = 1'b1;
      end else begin
        r = t[5:0];
      end
    end
    rem_next = r;
    quo_next = q;
  end

  // finish: magnitude, two partial products split at bit 32 of the magnitude, round, divide
  always_ff @(posedge clk) begin
    if (cmd.load_mag) begin
      neg <= sum[SUM_W-1];
      mag <= sum_abs[MAG_W-1:0];
    end
    if (cmd.mul_lo) begin
      part <= mag[LO_W-1:0] * step;
    end
    if (cmd.mul_hi) begin
      acc  <= ACC_W'(part) + ACC_W'(HALF_DIV);
      part <= mag[MAG_W-1:LO_W] * step;
    end
    if (cmd.add_hi) begin
      quo <= DIV_W'(acc_full[ACC_W-1:ROUND_SHIFT]);
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // saturate and restore the sign
  always_comb begin
    quo_ext = CMP_W'(quo);
    limit   = neg ? NEG_LIMIT : POS_LIMIT;
    over    = (quo_ext > CMP_W'(limit));
    res     = over ? limit : quo_ext[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      integral  <= neg ? -res : res;
      saturated <= over;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

// ----- rtl/newton_cotes_integrator.sv -----
`timescale 1ns / 1ps
// Throughput: one sample per cycle within a run while busy is low (start may stay high).
// Finish: once the last sample of a run is taken, it drains through the product and sum
// registers, then come two passes of the multiplier (low and high magnitude parts) and
// a divide by 45 that retires four quotient bits a cycle. busy is high over that span.
// done is high for a single cycle; integral holds until the next. The receiver cannot stall.
// Reset (rst, synchronous): run length 2, step 1.0, empty run, no result pending.

module newton_cotes_integrator
  import nci_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       wr_en,
  input  logic [0:0]                 wr_index,
  input  logic [CFG_W-1:0]           wr_data,
  output logic signed [63:0]         integral,
  output logic                       saturated,
  output logic                       done
);

  localparam int IDX_W     = $clog2(MAX_SAMPLES);
  localparam int SUM_W     = 44 + IDX_W;
  localparam int MAG_W     = SUM_W - 1;
  localparam int QUO_W     = MAG_W + STEP_W + 1 - ROUND_SHIFT;
  localparam int DIV_W     = ((QUO_W + 3) / 4) * 4;
  localparam int DIV_STEPS = DIV_W / 4;

  nci_cmd_t cmd;

  nci_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .DIV_STEPS   (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .busy     (busy),
    .cmd      (cmd)
  );

  nci_dp #(
    .SUM_W (SUM_W),
    .MAG_W (MAG_W),
    .DIV_W (DIV_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .sample    (sample),
    .integral  (integral),
    .saturated (saturated),
    .done      (done)
  );

endmodule

// ----- rtl/nci_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nci_checker
  import nci_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic               saturated,
  input logic signed [63:0] integral
);

  // a result beat lasts one cycle and ends the finish sequence
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `ASSERT_SAME(a_done_after_busy, clk, rst, done, $past(busy))
  // a clipped result sits on one of the two limits
  `ASSERT_SAME(a_sat_limit, clk, rst, done && saturated, integral == POS_LIMIT || integral == NEG_LIMIT)

endmodule

bind newton_cotes_integrator nci_checker u_nci_checker (.*);
